// ----- rtl/lwpf_pkg.sv -----
// ----------------------------------------------------------------------------
// lwpf_pkg
// Shared types and constants of the LCD window/pixel formatter.
// ----------------------------------------------------------------------------
package lwpf_pkg;

  // Display controller command bytes
  localparam logic [7:0] CMD_COLUMN   = 8'h2A;
  localparam logic [7:0] CMD_ROW      = 8'h2B;
  localparam logic [7:0] CMD_WRITE    = 8'h2C;
  localparam logic [7:0] CMD_CONTRAST = 8'h25;

  localparam logic [6:0] CONTRAST_MASK = 7'h7F;

  // Configuration register widths and reset values
  localparam int unsigned FRAME_W_BITS = 9;
  localparam logic                    PIXEL_MODE_RESET  = 1'b1;
  localparam logic [FRAME_W_BITS-1:0] FRAME_WIDTH_RESET = 9'd98;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  typedef enum logic [1:0] {
    KIND_WINDOW   = 2'd0,
    KIND_PIXEL    = 2'd1,
    KIND_CONTRAST = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_PIXEL_MODE  = 2'd0,
    REG_FRAME_WIDTH = 2'd1
  } reg_idx_t;

  // Work unit handed from the front to the back
  typedef enum logic [1:0] {
    OP_WINDOW   = 2'd0,
    OP_PIXEL8   = 2'd1,
    OP_PAIR     = 2'd2,
    OP_CONTRAST = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } cmd_t;

endpackage

// ----- rtl/lwpf_front.sv -----
// ----------------------------------------------------------------------------
// lwpf_front
// Accepts requests, keeps configuration and pixel pairing state, and turns
// each request into at most one work unit for the back end.
// ----------------------------------------------------------------------------
module lwpf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic [1:0]                        kind,
  input  logic [7:0]                        x_start,
  input  logic [7:0]                        y_start,
  input  logic [7:0]                        x_end,
  input  logic [7:0]                        y_end,
  input  logic [11:0]                       pixel,
  input  logic [7:0]                        contrast,
  input  logic                              cfg_valid,
  input  logic [1:0]                        cfg_index,
  input  logic [lwpf_pkg::FRAME_W_BITS-1:0] cfg_data,
  output logic                              q_push,
  output lwpf_pkg::cmd_t                    q_data,
  input  logic                              q_full
);
  import lwpf_pkg::*;

  logic                    pixel_mode;
  logic [FRAME_W_BITS-1:0] frame_width;
  logic [11:0]             held_pixel;
  logic                    pair_half;

  logic                    accept;
  logic [7:0]              xs_adj;
  logic [7:0]              xe_adj;
  logic [FRAME_W_BITS-1:0] xe_inc;

  assign accept = push && !q_full;
  assign xe_inc = {1'b0, x_end} + 9'd1;

  // 12-bit mode wants an odd end column: widen right, or move start left
  always_comb begin
    xs_adj = x_start;
    xe_adj = x_end;
    if (pixel_mode && !x_end[0]) begin
      if (xe_inc < frame_width) begin
        xe_adj = x_end + 8'd1;
      end else if (x_start != 8'd0) begin
        xs_adj = x_start - 8'd1;
      end
    end
  end

  always_comb begin
    q_push  = 1'b0;
    q_data  = '{op: OP_PIXEL8, b0: 8'd0, b1: 8'd0, b2: 8'd0, b3: 8'd0};
    case (kind)
      KIND_WINDOW: begin
        q_push = accept;
        q_data = '{op: OP_WINDOW, b0: xs_adj, b1: xe_adj, b2: y_start, b3: y_end};
      end
      KIND_PIXEL: begin
        if (pixel_mode) begin
          q_push = accept && pair_half;
          q_data = '{op: OP_PAIR, b0: held_pixel[11:4],
                     b1: {held_pixel[3:0], pixel[11:8]}, b2: pixel[7:0], b3: 8'd0};
        end else begin
          q_push = accept;
          q_data.b0 = pixel[7:0];
        end
      end
      KIND_CONTRAST: begin
        q_push = accept;
        q_data = '{op: OP_CONTRAST, b0: {1'b0, contrast[6:0] & CONTRAST_MASK},
                   b1: 8'd0, b2: 8'd0, b3: 8'd0};
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode  <= PIXEL_MODE_RESET;
      frame_width <= FRAME_WIDTH_RESET;
      pair_half   <= 1'b0;
    end else begin
      // A mode write drops a held pixel; otherwise a window drops it and a
      // 12-bit pixel flips the pair phase
      if (cfg_valid && cfg_index == REG_PIXEL_MODE) begin
        pair_half <= 1'b0;
      end else if (accept && kind == KIND_WINDOW) begin
        pair_half <= 1'b0;
      end else if (accept && kind == KIND_PIXEL && pixel_mode) begin
        pair_half <= !pair_half;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_PIXEL_MODE: begin
            pixel_mode <= cfg_data[0];
          end
          REG_FRAME_WIDTH: begin
            frame_width <= cfg_data;
          end
          default: begin
            frame_width <= frame_width;
          end
        endcase
      end
    end
  end

  // Hold the first pixel of a pair
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_PIXEL && pixel_mode && !pair_half) begin
      held_pixel <= pixel;
    end
  end

endmodule

// ----- rtl/lwpf_queue.sv -----
// ----------------------------------------------------------------------------
// lwpf_queue
// Small register queue of work units between front and back.
// ----------------------------------------------------------------------------
module lwpf_queue #(
  parameter int unsigned DEPTH = lwpf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  lwpf_pkg::cmd_t wr_data,
  output logic           q_full,
  input  logic           rd,
  output lwpf_pkg::cmd_t rd_data,
  output logic           q_empty
);
  import lwpf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- rtl/lwpf_back.sv -----
// ----------------------------------------------------------------------------
// lwpf_back
// Expands work units into 9-bit link words, one per cycle while the output
// register is empty or being popped, and holds each word in that register.
// ----------------------------------------------------------------------------
module lwpf_back (
  input  logic           clk,
  input  logic           rst,
  input  lwpf_pkg::cmd_t head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic           is_data,
  output logic [7:0]     byte_out,
  output logic           last
);
  import lwpf_pkg::*;

  logic       out_valid;
  logic [2:0] step;
  logic       load;
  logic       advance;
  logic       w_data;
  logic [7:0] w_byte;
  logic       w_last;

  assign empty   = !out_valid;
  assign load    = !out_valid || pop;
  assign advance = load && !q_empty;
  assign q_pop   = advance && w_last;

  always_comb begin
    w_data = 1'b1;
    w_byte = head.b0;
    w_last = 1'b0;
    case (head.op)
      OP_WINDOW: begin
        case (step)
          3'd0: begin w_data = 1'b0; w_byte = CMD_COLUMN; end
          3'd1: w_byte = head.b0;
          3'd2: w_byte = head.b1;
          3'd3: begin w_data = 1'b0; w_byte = CMD_ROW; end
          3'd4: w_byte = head.b2;
          3'd5: w_byte = head.b3;
          default: begin w_data = 1'b0; w_byte = CMD_WRITE; w_last = 1'b1; end
        endcase
      end
      OP_PAIR: begin
        case (step)
          3'd0: w_byte = head.b0;
          3'd1: w_byte = head.b1;
          default: begin w_byte = head.b2; w_last = 1'b1; end
        endcase
      end
      OP_CONTRAST: begin
        if (step == 3'd0) begin
          w_data = 1'b0;
          w_byte = CMD_CONTRAST;
        end else begin
          w_last = 1'b1;
        end
      end
      default: begin
        w_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      step      <= w_last ? 3'd0 : step + 3'd1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_data  <= w_data;
      byte_out <= w_byte;
      last     <= w_last;
    end
  end

endmodule

// ----- rtl/lcd_window_pixel_formatter.sv -----
// ----------------------------------------------------------------------------
// lcd_window_pixel_formatter
// Turns window, pixel and contrast requests into 9-bit serial LCD words.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-style port: an item is taken at a clock
//   edge with push high and full low. Results leave the same way: while empty
//   is low the oldest word (is_data, byte_out, last) is shown, and pop takes it.
//   last marks the final word caused by one request.
//   A window gives seven words, a contrast request two, an 8-bit pixel one,
//   and in 12-bit mode every second pixel gives three words (the first only
//   is held). Words leave at one per cycle while the receiver keeps popping
//   them, and a request holds the back end's word sequencer until all its
//   words are loaded. The first word passes through the queue, where the work
//   unit lands at the accepting edge, and is then loaded into the output register.
//   Requests keep being taken while fewer than QUEUE_DEPTH work units wait,
//   so a stalled receiver fills the queue first and then raises full.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 pixel_mode,
//   1 frame_width) and cfg_data; write only while the block is idle. Writing
//   pixel_mode drops a held pixel.
//   Reset (rst, synchronous) empties the queue and output register and
//   restores 12-bit mode with a frame width of 98.
// ----------------------------------------------------------------------------
module lcd_window_pixel_formatter #(
  parameter int unsigned QUEUE_DEPTH = lwpf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // request side
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        kind,
  input  logic [7:0]                        x_start,
  input  logic [7:0]                        y_start,
  input  logic [7:0]                        x_end,
  input  logic [7:0]                        y_end,
  input  logic [11:0]                       pixel,
  input  logic [7:0]                        contrast,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [lwpf_pkg::FRAME_W_BITS-1:0] cfg_data,
  // word side
  output logic                              empty,
  input  logic                              pop,
  output logic                              is_data,
  output logic [7:0]                        byte_out,
  output logic                              last
);
  import lwpf_pkg::*;

  logic q_push;
  cmd_t q_wdata;
  logic q_full;
  logic q_pop;
  cmd_t q_head;
  logic q_empty;

  // Registers are always writable
  assign cfg_ready = 1'b1;
  assign full      = q_full;

  // Front: classify requests, pair pixels, adjust windows
  lwpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .kind      (kind),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .pixel     (pixel),
    .contrast  (contrast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  // Decouple the front from the word sequencer
  lwpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_data (q_head),
    .q_empty (q_empty)
  );

  // Back: emit one word per cycle into the output register while it is free or popped
  lwpf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .is_data  (is_data),
    .byte_out (byte_out),
    .last     (last)
  );

endmodule

// ----- rtl/lwpf_checker.sv -----
// ----------------------------------------------------------------------------
// lwpf_checker
// Port-level checks of the LCD window/pixel formatter, bound to the top level.
// ----------------------------------------------------------------------------
module lwpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic       is_data,
  input logic [7:0] byte_out,
  input logic       last
);
  import lwpf_pkg::*;

  // Nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // A waiting word holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(byte_out) && $stable(is_data) && $stable(last)))
    else $error("waiting word changed");

  // Memory-write command closes every window
  a_write_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !is_data && byte_out == CMD_WRITE) |-> last)
    else $error("memory-write command not last");

  // Contrast command is followed at once by its data word
  a_contrast_pair: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !is_data && byte_out == CMD_CONTRAST)
      |-> (!last ##1 (!empty && is_data && last && !byte_out[7])))
    else $error("contrast command not followed by its value");

endmodule

bind lcd_window_pixel_formatter lwpf_checker u_lwpf_checker (
  .clk      (clk),
  .rst      (rst),
  .empty    (empty),
  .pop      (pop),
  .is_data  (is_data),
  .byte_out (byte_out),
  .last     (last)
);
